// ----- design/red_pkg.sv -----
`timescale 1ns / 1ps

package red_pkg;

    // Field widths.
    localparam int COORD_W = 32;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int FRAC_W  = 8;
    localparam int DIST_W  = 25;

    // Distance mode codes.
    typedef enum logic {
        MODE_2D = 1'b0,
        MODE_3D = 1'b1
    } mode_t;

    // One input item: two points in signed Q24.8.
    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
    } point_pair_t;

    // One result item.
    typedef struct packed {
        logic [DIST_W-1:0] rounded_distance;
    } dist_t;

    // Configuration write data.
    typedef struct packed {
        logic distance_mode;
    } cfg_t;

endpackage

// ----- design/red_chan_if.sv -----
`timescale 1ns / 1ps

// Valid/ready channel carrying one item of type payload_t.
interface red_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/red_sqsum.sv -----
`timescale 1ns / 1ps

// Three stages: difference magnitudes, squares, sum of squares.
module red_sqsum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  red_pkg::mode_t            mode,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  red_pkg::point_pair_t      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [red_pkg::SUM_W-1:0] out_sum
);

    logic                      s1_valid_reg;
    logic [red_pkg::MAG_W-1:0] mag_x_reg;
    logic [red_pkg::MAG_W-1:0] mag_y_reg;
    logic [red_pkg::MAG_W-1:0] mag_z_reg;
    logic [red_pkg::MAG_W-1:0] mag_x_next;
    logic [red_pkg::MAG_W-1:0] mag_y_next;
    logic [red_pkg::MAG_W-1:0] mag_z_next;

    logic                     s2_valid_reg;
    logic [red_pkg::SQ_W-1:0] sq_x_reg;
    logic [red_pkg::SQ_W-1:0] sq_y_reg;
    logic [red_pkg::SQ_W-1:0] sq_z_reg;

    logic                      s3_valid_reg;
    logic [red_pkg::SUM_W-1:0] sum_reg;
    logic [red_pkg::SUM_W-1:0] sum_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    // A stage takes new data when it is empty or its content moves on.
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Magnitude of a coordinate difference; it always fits in 32 bits.
    function automatic logic [red_pkg::MAG_W-1:0] abs_diff(
        input logic signed [red_pkg::COORD_W-1:0] a,
        input logic signed [red_pkg::COORD_W-1:0] b
    );
        logic signed [red_pkg::COORD_W:0] d;
        logic [red_pkg::COORD_W:0]        m;
        d = {a[red_pkg::COORD_W-1], a} - {b[red_pkg::COORD_W-1], b};
        m = d[red_pkg::COORD_W] ? (~d + 1'b1) : d;
        return m[red_pkg::MAG_W-1:0];
    endfunction

    always_comb
    begin
        mag_x_next = abs_diff(in_data.first_x, in_data.second_x);
        mag_y_next = abs_diff(in_data.first_y, in_data.second_y);
        if (mode == red_pkg::MODE_3D)
        begin
            mag_z_next = abs_diff(in_data.first_z, in_data.second_z);
        end
        else
        begin
            mag_z_next = '0;
        end
    end

    // Sum of the three squares, widened so it cannot wrap.
    assign sum_next = {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            mag_z_reg <= mag_z_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            sq_x_reg <= mag_x_reg * mag_x_reg;
            sq_y_reg <= mag_y_reg * mag_y_reg;
            sq_z_reg <= mag_z_reg * mag_z_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_sum   = sum_reg;

endmodule

// ----- design/red_isqrt.sv -----
`timescale 1ns / 1ps

// Integer square root, one root bit per pipeline stage (restoring method).
module red_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [red_pkg::SUM_W-1:0]  in_sum,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [red_pkg::ROOT_W-1:0] out_root
);

    localparam int NST = red_pkg::ROOT_W;
    localparam int RW  = red_pkg::REM_W;

    genvar i;
    generate
        for (i = 0; i < NST; i++)
        begin : g_stage
            logic                       valid_reg;
            logic [red_pkg::SUM_W-1:0]  num_reg;
            logic [RW-1:0]              rem_reg;
            logic [red_pkg::ROOT_W-1:0] root_reg;
            logic                       stage_ready;
            logic                       next_ready;
            logic                       prev_valid;
            logic [red_pkg::SUM_W-1:0]  prev_num;
            logic [RW-1:0]              prev_rem;
            logic [red_pkg::ROOT_W-1:0] prev_root;
            logic [RW+1:0]              cur_rem;
            logic [RW+1:0]              trial;
            logic [RW+1:0]              diff;
            logic                       take;
            logic [RW-1:0]              rem_next;
            logic [red_pkg::ROOT_W-1:0] root_next;

            // Stage inputs: the first stage starts from a zero remainder and root.
            if (i == 0)
            begin : g_first
                assign prev_valid = in_valid;
                assign prev_num   = in_sum;
                assign prev_rem   = '0;
                assign prev_root  = '0;
            end
            else
            begin : g_rest
                assign prev_valid = g_stage[i-1].valid_reg;
                assign prev_num   = g_stage[i-1].num_reg;
                assign prev_rem   = g_stage[i-1].rem_reg;
                assign prev_root  = g_stage[i-1].root_reg;
            end

            // The last stage hands its item to the output; the others to the next stage.
            if (i == NST - 1)
            begin : g_last
                assign next_ready = out_ready;
            end
            else
            begin : g_mid
                assign next_ready = g_stage[i+1].stage_ready;
            end

            assign stage_ready = !valid_reg || next_ready;

            // Bring down the next two radicand bits and try the next root bit.
            always_comb
            begin
                cur_rem   = {prev_rem, prev_num[red_pkg::SUM_W-1-2*i -: 2]};
                trial     = {2'b00, prev_root[red_pkg::ROOT_W-2:0], 2'b01};
                diff      = cur_rem - trial;
                take      = (cur_rem >= trial);
                rem_next  = take ? diff[RW-1:0] : cur_rem[RW-1:0];
                root_next = {prev_root[red_pkg::ROOT_W-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg <= 1'b0;
                end
                else if (stage_ready)
                begin
                    valid_reg <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready && prev_valid)
                begin
                    num_reg  <= prev_num;
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                end
            end
        end
    endgenerate

    assign in_ready  = g_stage[0].stage_ready;
    assign out_valid = g_stage[NST-1].valid_reg;
    assign out_root  = g_stage[NST-1].root_reg;

endmodule

// ----- design/rounded_euclidean_distance.sv -----
`timescale 1ns / 1ps

// Channel    Dir  Payload
// points     in   first_x/y/z, second_x/y/z, signed Q24.8, 32 bits each
// cfg        in   distance_mode (0: 2D, 1: 3D)
// distance   out  rounded_distance, 25 bits unsigned
//
// One item enters per cycle while the distance channel does not stall. The
// pipeline has three stages for differences, squares and sum, 33 square-root
// stages (one root bit each), and the rounding output register.
// Reset clears the mode (2D) and all valid bits.
// Each stage holds its item while the next one is full, so a stall on the
// distance channel backs up stage by stage without losing or repeating items.
module rounded_euclidean_distance (
    input  logic        clk,
    input  logic        rst_n,
    red_chan_if.sink    points,
    red_chan_if.sink    cfg,
    red_chan_if.source  distance
);

    red_pkg::mode_t mode_reg;

    logic                       sum_valid;
    logic                       sum_ready;
    logic [red_pkg::SUM_W-1:0]  sum;
    logic                       root_valid;
    logic                       root_ready;
    logic [red_pkg::ROOT_W-1:0] root;

    logic                       out_valid_reg;
    logic [red_pkg::DIST_W-1:0] dist_reg;
    logic [red_pkg::ROOT_W:0]   round_sum;

    // Mode register; writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= red_pkg::MODE_2D;
        end
        else if (cfg.valid)
        begin
            mode_reg <= red_pkg::mode_t'(cfg.data.distance_mode);
        end
    end

    red_sqsum u_sqsum (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .in_valid  (points.valid),
        .in_ready  (points.ready),
        .in_data   (points.data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum)
    );

    red_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_sum    (sum),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_root  (root)
    );

    // Root is at 2^-8 scale; add one half and drop the fraction.
    assign round_sum  = {1'b0, root} + (red_pkg::ROOT_W + 1)'(1 << (red_pkg::FRAC_W - 1));
    assign root_ready = !out_valid_reg || distance.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (root_ready)
        begin
            out_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (root_ready && root_valid)
        begin
            dist_reg <= round_sum[red_pkg::FRAC_W +: red_pkg::DIST_W];
        end
    end

    assign distance.valid                 = out_valid_reg;
    assign distance.data.rounded_distance = dist_reg;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int PHASE_PAIRS = 125;
    localparam int PHASE_COUNT = 8;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n;

    red_chan_if #(.payload_t(red_pkg::point_pair_t)) pts_if ();
    red_chan_if #(.payload_t(red_pkg::cfg_t))        cfg_if ();
    red_chan_if #(.payload_t(red_pkg::dist_t))       dist_if ();

    rounded_euclidean_distance u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .points   (pts_if),
        .cfg      (cfg_if),
        .distance (dist_if)
    );

    // Point pairs waiting to be sent and distances waiting to come back.
    red_pkg::point_pair_t       pair_backlog[$];
    logic [red_pkg::DIST_W-1:0] expected_dist[$];

    red_pkg::mode_t mode_now = red_pkg::MODE_2D;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    mismatch_count = 0;

    // Free-running clock.
    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Squared magnitude of the difference of two signed coordinates.
    function automatic logic [63:0] sq_diff(input logic signed [red_pkg::COORD_W-1:0] a,
                                            input logic signed [red_pkg::COORD_W-1:0] b);
        logic signed [red_pkg::COORD_W:0] d;
        logic [63:0]                      m;
        d = a - b;
        m = d[red_pkg::COORD_W] ? 64'(-d) : 64'(d);
        return m * m;
    endfunction

    // Distance in whole units: floor of the exact root at 2^-8 scale, then rounded.
    function automatic logic [red_pkg::DIST_W-1:0] nint_distance(input red_pkg::point_pair_t p,
                                                                 input red_pkg::mode_t m);
        logic [65:0] sum;
        logic [33:0] root;
        logic [33:0] trial;
        logic [67:0] trial_sq;
        logic [34:0] rounded;
        sum = 66'(sq_diff(p.first_x, p.second_x)) + 66'(sq_diff(p.first_y, p.second_y));
        if (m == red_pkg::MODE_3D)
            sum = sum + 66'(sq_diff(p.first_z, p.second_z));
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            trial = root | (34'd1 << b);
            trial_sq = 68'(trial) * 68'(trial);
            if (trial_sq <= 68'(sum))
                root = trial;
        end
        rounded = (35'(root) + 35'd128) >> red_pkg::FRAC_W;
        return rounded[red_pkg::DIST_W-1:0];
    endfunction

    function automatic red_pkg::point_pair_t build_pair(input logic signed [31:0] fx,
                                                        input logic signed [31:0] fy,
                                                        input logic signed [31:0] fz,
                                                        input logic signed [31:0] sx,
                                                        input logic signed [31:0] sy,
                                                        input logic signed [31:0] sz);
        red_pkg::point_pair_t p;
        p.first_x = fx;
        p.first_y = fy;
        p.first_z = fz;
        p.second_x = sx;
        p.second_y = sy;
        p.second_z = sz;
        return p;
    endfunction

    function automatic logic signed [31:0] corner_coord();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int small_offset();
        return int'($urandom_range(8191)) - 4096;
    endfunction

    // Random pair: mostly full-range or close points, plus rounding edges,
    // corner values and coincident points.
    function automatic red_pkg::point_pair_t random_pair();
        red_pkg::point_pair_t p;
        int                   kind;
        int                   step;
        kind = $urandom_range(99);
        p = build_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (kind < 30)
        begin
        end
        else if (kind < 60)
        begin
            p.second_x = p.first_x + small_offset();
            p.second_y = p.first_y + small_offset();
            p.second_z = p.first_z + small_offset();
        end
        else if (kind < 75)
        begin
            // One axis differs by about n + 1/2 units, the others not at all.
            step = (int'($urandom_range(200)) << red_pkg::FRAC_W) + 128
                   + int'($urandom_range(2)) - 1;
            if ($urandom_range(1))
                step = -step;
            p.second_x = p.first_x;
            p.second_y = p.first_y;
            p.second_z = p.first_z;
            case ($urandom_range(2))
                0: p.second_x = p.first_x + step;
                1: p.second_y = p.first_y + step;
                default: p.second_z = p.first_z + step;
            endcase
        end
        else if (kind < 90)
        begin
            p = build_pair(corner_coord(), corner_coord(), corner_coord(),
                           corner_coord(), corner_coord(), corner_coord());
        end
        else
        begin
            p.second_x = p.first_x;
            p.second_y = p.first_y;
            p.second_z = p.first_z;
        end
        return p;
    endfunction

    // Point driver: predicts the distance of each accepted item.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pts_if.valid <= 1'b0;
        end
        else
        begin
            if (pts_if.valid && pts_if.ready)
                expected_dist.push_back(nint_distance(pts_if.data, mode_now));
            if (!pts_if.valid || pts_if.ready)
            begin
                if (pair_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pts_if.valid <= 1'b1;
                    pts_if.data <= pair_backlog.pop_front();
                end
                else
                begin
                    pts_if.valid <= 1'b0;
                end
            end
        end
    end

    // Distance monitor: checks each accepted item against the oldest prediction.
    always @(posedge clk)
    begin : dist_monitor
        logic [red_pkg::DIST_W-1:0] want;
        if (!rst_n)
        begin
            dist_if.ready <= 1'b0;
        end
        else
        begin
            if (dist_if.valid && dist_if.ready)
            begin
                if (expected_dist.size() == 0)
                begin
                    report_mismatch($sformatf("distance %0d arrived with nothing pending",
                                              dist_if.data.rounded_distance));
                end
                else
                begin
                    want = expected_dist.pop_front();
                    if (dist_if.data.rounded_distance !== want)
                        report_mismatch($sformatf("rounded_distance %0d, predicted %0d",
                                                  dist_if.data.rounded_distance, want));
                end
            end
            dist_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Write the mode register; only called while the block is idle.
    task automatic write_mode(input red_pkg::mode_t m);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data.distance_mode <= m;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        mode_now = m;
    endtask

    task automatic wait_drained();
        while (pair_backlog.size() != 0 || pts_if.valid || expected_dist.size() != 0)
            @(posedge clk);
    endtask

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        int drain_cycles;
        rst_n = 1'b0;
        pts_if.valid = 1'b0;
        pts_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        dist_if.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs in the reset mode (2D).
        pair_backlog.push_back(build_pair(0, 0, 0, 0, 0, 0));
        pair_backlog.push_back(build_pair(32'h1234_5678, -32'sd98765, 7, 32'h1234_5678,
                                          -32'sd98765, 7));
        pair_backlog.push_back(build_pair(0, 0, 0, 3 << 8, 4 << 8, 0));
        pair_backlog.push_back(build_pair(0, 0, 0, 32'sh80, 0, 0));
        pair_backlog.push_back(build_pair(0, 0, 0, 32'sh7F, 0, 0));
        pair_backlog.push_back(build_pair(0, 32'sh280, 0, 0, 0, 0));
        pair_backlog.push_back(build_pair(5, 6, 32'sh8000_0000, 5, 6, 32'sh7FFF_FFFF));
        pair_backlog.push_back(build_pair(32'sh8000_0000, 32'sh8000_0000, 0,
                                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
        pair_backlog.push_back(build_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                                          32'sh8000_0000, 32'sh7FFF_FFFF, 0));
        pair_backlog.push_back(build_pair(-1, -1, -1, 0, 0, 0));
        wait_drained();

        // Directed pairs in 3D.
        write_mode(red_pkg::MODE_3D);
        pair_backlog.push_back(build_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        pair_backlog.push_back(build_pair(0, 0, 0, 2 << 8, 3 << 8, 6 << 8));
        pair_backlog.push_back(build_pair(0, 0, 32'sh180, 0, 0, 0));
        pair_backlog.push_back(build_pair(-9, 44, 32'sh7FFF_FFFF, -9, 44, 32'sh7FFF_FFFF));
        pair_backlog.push_back(build_pair(0, 0, 0, -(1 << 8), -(2 << 8), -(2 << 8)));
        pair_backlog.push_back(build_pair(32'sh7FFF_FFFF, 0, 32'sh8000_0000,
                                          32'sh8000_0000, -1, 32'sh7FFF_FFFF));
        pair_backlog.push_back(build_pair(0, 0, 0, 0, 0, 32'sh80));
        wait_drained();

        // Random phases: each idling pattern is run in both modes.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_mode(((ph / 4 + ph) % 2) ? red_pkg::MODE_3D : red_pkg::MODE_2D);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int i = 0; i < PHASE_PAIRS; i++)
                pair_backlog.push_back(random_pair());
            if (ph != PHASE_COUNT - 1)
                wait_drained();
        end

        // Let every accepted item come back, then watch for stray results.
        while (pair_backlog.size() != 0 || pts_if.valid)
            @(posedge clk);
        drain_cycles = 0;
        while (expected_dist.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_dist.size() != 0)
            report_mismatch($sformatf("%0d distances never arrived", expected_dist.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
